FILE: src/rmd160_pkg.sv
`timescale 1ns / 1ps
// rmd160_pkg: constants, step tables, types and helper functions for the hash core
// no dependencies

package rmd160_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned STEPS    = 80;
    localparam int unsigned CHAIN_N  = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_RUN,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PD_MARK,
        PD_ZERO,
        PD_LEN
    } t_pad;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] CHAIN_INIT [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0 };
    localparam logic [31:0] ADD_L [0:4] = '{
        32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E };
    localparam logic [31:0] ADD_R [0:4] = '{
        32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000 };

    localparam logic [3:0] SEL_L [0:79] = '{
        4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
        4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
        4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
        4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
        4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13 };
    localparam logic [3:0] SEL_R [0:79] = '{
        4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
        4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
        4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
        4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
        4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11 };
    localparam logic [3:0] ROT_L [0:79] = '{
        4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,4'd9,4'd8,
        4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
        4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
        4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12,
        4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,4'd6 };
    localparam logic [3:0] ROT_R [0:79] = '{
        4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,4'd12,4'd6,
        4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
        4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
        4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8,
        4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,4'd11 };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] mix(input logic [2:0] kind, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        logic [31:0] f;
        case (kind)
            3'd0:    f = x ^ y ^ z;
            3'd1:    f = (x & y) | (~x & z);
            3'd2:    f = (x | ~y) ^ z;
            3'd3:    f = (x & z) | (y & ~z);
            default: f = x ^ (y | ~z);
        endcase
        return f;
    endfunction

endpackage

FILE: src/rmd160_ram.sv
`timescale 1ns / 1ps
// rmd160_ram: generic single-write, single-read ram with registered read data
// no dependencies

module rmd160_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ripemd160_hash.sv
`timescale 1ns / 1ps
// ripemd160_hash: byte-stream ripemd-160 hash core, top level
// depends on rmd160_pkg and rmd160_ram
//
// input: bytes are taken only in idle; the 64th byte of a block starts a compression of
//   a read-ahead load, 80 steps and a chaining fold, where each step reads one word
//   per line from the block word rams
// message end: one padding byte per cycle between compressions, and one or two
//   compressions, then five digest items, one per accepted output cycle
// reset (i_rst_n low, synchronous) loads the initial chaining words, clears the
//   byte counts and returns to idle; the block word rams are not cleared

module ripemd160_hash
    import rmd160_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    // control state
    t_state      r_state, n_state;
    t_pad        r_pad, n_pad;
    logic        r_padding, n_padding;   // message end seen, padding in progress
    logic        r_pad_done, n_pad_done; // length bytes all placed
    logic [5:0]  r_fill, n_fill;         // bytes in the current block
    logic [60:0] r_total, n_total;       // message byte count, wraps at 2^61
    logic [6:0]  r_step, n_step;         // compression step
    logic [2:0]  r_idx, n_idx;           // digest word being sent

    // datapath
    logic [31:0] r_word, n_word;         // partial little-endian word
    logic [31:0] r_chain [0:4];
    logic [31:0] n_chain [0:4];
    logic [31:0] r_l [0:4];              // left line a..e
    logic [31:0] n_l [0:4];
    logic [31:0] r_r [0:4];              // right line a..e
    logic [31:0] n_r [0:4];

    // byte insertion into the block
    logic        put_en;
    logic [7:0]  put_val;
    logic [31:0] put_word;
    logic        ram_we;
    logic [3:0]  raddr_l, raddr_r;
    logic [31:0] rdata_l, rdata_r;
    logic [63:0] bit_len;
    logic [6:0]  step_nxt;
    logic [2:0]  rnd;
    logic [31:0] t_l, t_r;
    logic        in_acc;

    assign bit_len  = {r_total, 3'b000};
    assign put_word = {put_val, r_word[31:8]};
    assign ram_we   = put_en && (r_fill[1:0] == 2'd3);
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // read ahead one step: the ram answers in the next cycle
    assign step_nxt = (r_step == 7'(STEPS - 1)) ? 7'd0 : r_step + 7'd1;
    assign raddr_l  = (r_state == ST_RUN) ? SEL_L[step_nxt] : SEL_L[0];
    assign raddr_r  = (r_state == ST_RUN) ? SEL_R[step_nxt] : SEL_R[0];

    // two copies so both lines fetch their word in the same cycle
    rmd160_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[5:2]),
        .i_wdata (put_word),
        .i_raddr (raddr_l),
        .o_rdata (rdata_l)
    );

    rmd160_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[5:2]),
        .i_wdata (put_word),
        .i_raddr (raddr_r),
        .o_rdata (rdata_r)
    );

    // round number is step / 16
    assign rnd = r_step[6:4];

    // one step of each line
    assign t_l = rotl(r_l[0] + mix(rnd, r_l[1], r_l[2], r_l[3]) + rdata_l + ADD_L[rnd],
                      ROT_L[r_step]) + r_l[4];
    assign t_r = rotl(r_r[0] + mix(3'd4 - rnd, r_r[1], r_r[2], r_r[3]) + rdata_r
                      + ADD_R[rnd], ROT_R[r_step]) + r_r[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pad      <= PD_MARK;
            r_padding  <= 1'b0;
            r_pad_done <= 1'b0;
            r_fill     <= '0;
            r_total    <= '0;
            r_step     <= '0;
            r_idx      <= '0;
            for (int i = 0; i < CHAIN_N; i++) begin
                r_chain[i] <= CHAIN_INIT[i];
            end
        end else begin
            r_state    <= n_state;
            r_pad      <= n_pad;
            r_padding  <= n_padding;
            r_pad_done <= n_pad_done;
            r_fill     <= n_fill;
            r_total    <= n_total;
            r_step     <= n_step;
            r_idx      <= n_idx;
            r_chain    <= n_chain;
        end
        r_word <= n_word;
        r_l    <= n_l;
        r_r    <= n_r;
    end

    always_comb begin
        n_state    = r_state;
        n_pad      = r_pad;
        n_padding  = r_padding;
        n_pad_done = r_pad_done;
        n_fill     = r_fill;
        n_total    = r_total;
        n_step     = r_step;
        n_idx      = r_idx;
        n_word     = r_word;
        n_chain    = r_chain;
        n_l        = r_l;
        n_r        = r_r;
        put_en     = 1'b0;
        put_val    = 8'h00;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0]) begin
                        put_en  = 1'b1;
                        put_val = s_axis_tdata;
                        n_total = r_total + 61'd1;
                    end
                    if (s_axis_tlast) begin
                        n_padding = 1'b1;
                        n_pad     = PD_MARK;
                        n_state   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                put_en = 1'b1;
                case (r_pad)
                    PD_MARK: put_val = PAD_MARK;
                    PD_ZERO: put_val = 8'h00;
                    PD_LEN:  put_val = bit_len[{r_fill[2:0], 3'b000} +: 8];
                    default: put_val = 8'h00;
                endcase
                if (r_pad == PD_LEN) begin
                    if (r_fill == 6'd63) begin
                        n_pad_done = 1'b1;
                    end
                end else if (r_fill + 6'd1 == LEN_POS) begin
                    n_pad = PD_LEN;
                end else begin
                    n_pad = PD_ZERO;
                end
            end
            ST_LOAD: begin
                for (int i = 0; i < CHAIN_N; i++) begin
                    n_l[i] = r_chain[i];
                    n_r[i] = r_chain[i];
                end
                n_step  = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                n_l[0] = r_l[4];
                n_l[4] = r_l[3];
                n_l[3] = rotl(r_l[2], 4'd10);
                n_l[2] = r_l[1];
                n_l[1] = t_l;
                n_r[0] = r_r[4];
                n_r[4] = r_r[3];
                n_r[3] = rotl(r_r[2], 4'd10);
                n_r[2] = r_r[1];
                n_r[1] = t_r;
                n_step = step_nxt;
                if (r_step == 7'(STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // fold both lines into the chaining words
                n_chain[0] = r_chain[1] + r_l[2] + r_r[3];
                n_chain[1] = r_chain[2] + r_l[3] + r_r[4];
                n_chain[2] = r_chain[3] + r_l[4] + r_r[0];
                n_chain[3] = r_chain[4] + r_l[0] + r_r[1];
                n_chain[4] = r_chain[0] + r_l[1] + r_r[2];
                if (r_pad_done) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else if (r_padding) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'(CHAIN_N - 1)) begin
                        // digest out: back to a fresh message
                        for (int i = 0; i < CHAIN_N; i++) begin
                            n_chain[i] = CHAIN_INIT[i];
                        end
                        n_fill     = '0;
                        n_total    = '0;
                        n_padding  = 1'b0;
                        n_pad_done = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // shared byte insertion; a full block starts a compression
        if (put_en) begin
            n_word = put_word;
            n_fill = r_fill + 6'd1;
            if (r_fill == 6'd63) begin
                n_state = ST_LOAD;
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = r_chain[r_idx];
    assign m_axis_tuser  = r_idx;
    assign m_axis_tlast  = (r_idx == 3'(CHAIN_N - 1));

    // input and output never open at once
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");

    // digest word index stays in range while sending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_idx <= 3'(CHAIN_N - 1)))
        else $error("digest index out of range");

    // a compression starts only from a full block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_fill == 6'd0))
        else $error("compression started on a partial block");

    // the step counter wraps to the fold exactly after the last step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == 7'(STEPS - 1)) |=> (r_state == ST_FIN))
        else $error("compression did not end after the last step");

endmodule

FILE: dv/ripemd160_hash_tb.sv
`timescale 1ns / 1ps
// ripemd160_hash_tb: self-checking bench for the byte-stream ripemd-160 core
// depends on ripemd160_hash

module ripemd160_hash_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] byte_valid
    logic        s_axis_tlast;   // message_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;   // last_word

    ripemd160_hash u_dut (.*);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_item;

    // own copy of the hashing state
    logic [31:0]  chain_q [0:4];
    logic [7:0]   block_buf [0:63];
    int unsigned  fill_cnt;
    logic [60:0]  msg_bytes;

    t_digest_item digest_queue[$];
    int           fail_cnt;
    int           digest_cnt;
    int           msg_cnt;
    bit           src_no_idle;
    bit           sink_no_idle;

    // the left and right step tables, kept locally so the model stands apart
    localparam int LSEL [0:79] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15, 7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12, 1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13 };
    localparam int RSEL [0:79] = '{
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12, 6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13, 8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
        12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11 };
    localparam int LROT [0:79] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8, 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5, 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6 };
    localparam int RROT [0:79] = '{
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6, 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5, 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
        8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11 };
    localparam logic [31:0] LK [0:4] = '{
        32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E };
    localparam logic [31:0] RK [0:4] = '{
        32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000 };
    localparam logic [31:0] IV [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0 };

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic logic [31:0] rol32(logic [31:0] v, int s);
        return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
    endfunction

    function automatic logic [31:0] bool_fn(int k, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
        case (k)
            0: return x ^ y ^ z;
            1: return (x & y) | (~x & z);
            2: return (x | ~y) ^ z;
            3: return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    // one block through both lines, then fold into the chain
    task automatic compress_block();
        logic [31:0] w [0:15];
        logic [31:0] al, bl, cl, dl, el, ar, br, cr, dr, er, t;
        int r;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
        al = chain_q[0]; bl = chain_q[1]; cl = chain_q[2]; dl = chain_q[3]; el = chain_q[4];
        ar = al; br = bl; cr = cl; dr = dl; er = el;
        for (int i = 0; i < 80; i++) begin
            r = i / 16;
            t = rol32(al + bool_fn(r, bl, cl, dl) + w[LSEL[i]] + LK[r], LROT[i]) + el;
            al = el; el = dl; dl = rol32(cl, 10); cl = bl; bl = t;
            t = rol32(ar + bool_fn(4 - r, br, cr, dr) + w[RSEL[i]] + RK[r], RROT[i]) + er;
            ar = er; er = dr; dr = rol32(cr, 10); cr = br; br = t;
        end
        t          = chain_q[1] + cl + dr;
        chain_q[1] = chain_q[2] + dl + er;
        chain_q[2] = chain_q[3] + el + ar;
        chain_q[3] = chain_q[4] + al + br;
        chain_q[4] = chain_q[0] + bl + cr;
        chain_q[0] = t;
    endtask

    task automatic absorb_byte(logic [7:0] b);
        block_buf[fill_cnt] = b;
        fill_cnt++;
        if (fill_cnt == 64) begin
            compress_block();
            fill_cnt = 0;
        end
    endtask

    task automatic hash_reset();
        for (int i = 0; i < 5; i++) chain_q[i] = IV[i];
        fill_cnt  = 0;
        msg_bytes = '0;
    endtask

    // predict the digest words caused by one accepted item
    task automatic predict_digest(logic [7:0] b, logic bv, logic fin);
        logic [63:0] bit_len;
        t_digest_item d;
        if (bv) begin
            absorb_byte(b);
            msg_bytes = msg_bytes + 1'b1;
        end
        if (fin) begin
            bit_len = {msg_bytes, 3'b000};
            absorb_byte(8'h80);
            while (fill_cnt != 56) absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) absorb_byte(bit_len[8*i +: 8]);
            for (int i = 0; i < 5; i++) begin
                d.word  = chain_q[i];
                d.index = 3'(i);
                d.last  = (i == 4);
                digest_queue.push_back(d);
            end
            hash_reset();
            msg_cnt++;
        end
    endtask

    // drive one item, hold it until accepted, predict at acceptance
    task automatic send_item(logic [7:0] b, logic bv, logic fin);
        while (!src_no_idle && $urandom_range(99) < 37) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = bv;
        s_axis_tlast  = fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_digest(b, bv, fin);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic wait_drain();
        while (digest_queue.size() != 0) @(negedge i_clk);
    endtask

    // sink side: random stalls, compare each accepted word with the oldest one
    always @(negedge i_clk)
        m_axis_tready <= !i_rst_n || sink_no_idle || ($urandom_range(99) >= 37);

    always @(posedge i_clk) begin
        t_digest_item e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            digest_cnt++;
            if (digest_queue.size() == 0) begin
                $error("unexpected digest word %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                e = digest_queue.pop_front();
                if (m_axis_tdata !== e.word) begin
                    $error("digest_word exp %h got %h", e.word, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tuser !== e.index) begin
                    $error("word_index exp %0d got %0d", e.index, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_word exp %0d got %0d", e.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // empty message, all-bits bytes, idle items and ignored bytes
    task automatic test_directed();
        send_item(8'hFF, 1'b0, 1'b1);               // empty message, data ignored
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);               // idle item
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b1);               // single byte "a"
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);               // end without a byte
    endtask

    // lengths around the padding edges: 55, 56, 63 and 64 bytes force one or two blocks
    task automatic test_block_edges();
        send_message(54);
        send_message(55);
        wait_drain();                               // sender holds off for all digests
        send_message(62);
        send_message(63);
    endtask

    // random messages with idle items and ignored bytes mixed in
    task automatic test_random(int n_items);
        int sent, len;
        logic bv;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
            for (int i = 0; i < len; i++) begin
                bv = ($urandom_range(7) != 0);
                send_item(8'($urandom), bv, 1'b0);
                sent++;
            end
            send_item(8'($urandom), 1'($urandom), 1'b1);
            sent++;
            if (sent > n_items / 2) src_no_idle = 1'b0;
            else if (sent > n_items / 4) begin
                src_no_idle  = 1'b1;                // long stretch with no idling
                sink_no_idle = 1'b1;
            end
            if (sent > n_items / 2) sink_no_idle = 1'b0;
        end
    endtask

    initial begin
        fail_cnt = 0; digest_cnt = 0; msg_cnt = 0;
        src_no_idle = 1'b0; sink_no_idle = 1'b0;
        hash_reset();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_block_edges();
        test_random(72);

        wait_drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d messages, %0d digest words, edge lengths and idle items",
                 msg_cnt, digest_cnt);
        if (fail_cnt == 0 && digest_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // timeout, several times the slowest run
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
